@@ rtl/core/alg_pkg.sv @@
// ----------------------------------------------------------------------------
// Auto level gain computer package
// Shared widths, constants, register indexes and controller/datapath types.
// ----------------------------------------------------------------------------
package alg_pkg;

  localparam int LEVEL_W    = 24;
  localparam int ENV_W      = 32;
  localparam int FACTOR_W   = 25;
  localparam int KNEE_W     = 24;
  localparam int COEF_W     = 32;
  localparam int GAIN_W     = 24;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int ACC_W      = 42;
  localparam int MUL_A_W    = 38;
  localparam int MUL_B_W    = 26;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int FRAC_SHIFT = 20;
  localparam int DIV_STEPS  = 23;
  localparam int CNT_W      = 5;

  localparam logic [FACTOR_W-1:0] FACTOR_ONE    = 25'd16777216;
  localparam logic [GAIN_W-1:0]   UNITY_GAIN    = 24'd8388608;
  localparam logic [KNEE_W-1:0]   SQRT_HALF_Q24 = 24'd11863283;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE  = 3'd0,
    REG_ATTACK  = 3'd1,
    REG_RELEASE = 3'd2,
    REG_KNEE_LO = 3'd3,
    REG_KNEE_HI = 3'd4,
    REG_SQUARE  = 3'd5,
    REG_LINEAR  = 3'd6,
    REG_CONST   = 3'd7
  } reg_index_t;

  typedef enum logic [2:0] {
    MUL_NONE     = 3'd0,
    MUL_ENV      = 3'd1,
    MUL_SQUARE   = 3'd2,
    MUL_POLY     = 3'd3,
    MUL_KNEE_END = 3'd4
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_NONE     = 2'd0,
    ACC_POLY     = 2'd1,
    ACC_TARGET   = 2'd2,
    ACC_KNEE_END = 2'd3
  } acc_op_t;

  typedef enum logic [1:0] {
    GAIN_HOLD  = 2'd0,
    GAIN_UNITY = 2'd1,
    GAIN_ZERO  = 2'd2
  } gain_op_t;

  typedef struct packed {
    logic                     enable;
    logic [FACTOR_W-1:0]      attack;
    logic [FACTOR_W-1:0]      release_f;
    logic [KNEE_W-1:0]        knee_start;
    logic [KNEE_W-1:0]        knee_end;
    logic signed [COEF_W-1:0] square;
    logic signed [COEF_W-1:0] linear;
    logic signed [COEF_W-1:0] offset;
  } alg_cfg_t;

  typedef struct packed {
    logic     capture;
    logic     env_clear;
    logic     env_update;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    gain_op_t gain_op;
    logic     div_init;
    logic     div_step;
    logic     load_out;
  } alg_cmd_t;

  typedef struct packed {
    logic above_start;
    logic above_end;
    logic target_nonpos;
    logic target_sat;
    logic div_last;
  } alg_status_t;

endpackage

@@ rtl/core/alg_cfg.sv @@
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the regulation settings and flags an envelope clear on disable.
// ----------------------------------------------------------------------------
module alg_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_en,
  input  logic [alg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alg_pkg::CFG_DATA_W-1:0] cfg_data,
  output alg_pkg::alg_cfg_t              cfg,
  output logic                           env_clear
);
  import alg_pkg::*;

  logic [FACTOR_W-1:0] factor_in;
  logic [FACTOR_W-1:0] factor_clamped;

  assign factor_in      = cfg_data[FACTOR_W-1:0];
  assign factor_clamped = (factor_in > FACTOR_ONE) ? FACTOR_ONE : factor_in;
  assign env_clear      = cfg_write_en && (reg_index_t'(cfg_index) == REG_ENABLE) &&
                          !cfg_data[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable     <= 1'b0;
      cfg.attack     <= FACTOR_ONE;
      cfg.release_f  <= FACTOR_ONE;
      cfg.knee_start <= '1;
      cfg.knee_end   <= '1;
      cfg.square     <= '0;
      cfg.linear     <= COEF_W'(FACTOR_ONE);
      cfg.offset     <= '0;
    end else if (cfg_write_en) begin
      unique case (reg_index_t'(cfg_index))
        REG_ENABLE:  cfg.enable     <= cfg_data[0];
        REG_ATTACK:  cfg.attack     <= factor_clamped;
        REG_RELEASE: cfg.release_f  <= factor_clamped;
        REG_KNEE_LO: cfg.knee_start <= cfg_data[KNEE_W-1:0];
        REG_KNEE_HI: cfg.knee_end   <= cfg_data[KNEE_W-1:0];
        REG_SQUARE:  cfg.square     <= $signed(cfg_data[COEF_W-1:0]);
        REG_LINEAR:  cfg.linear     <= $signed(cfg_data[COEF_W-1:0]);
        REG_CONST:   cfg.offset     <= $signed(cfg_data[COEF_W-1:0]);
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/core/alg_ctrl.sv @@
// ----------------------------------------------------------------------------
// Gain computer controller
// Sequences the envelope update, knee curve, saturation checks and divider.
// ----------------------------------------------------------------------------
module alg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 enable,
  input  alg_pkg::alg_status_t status,
  output alg_pkg::alg_cmd_t    cmd
);
  import alg_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_ENV_MUL  = 11'b000_0000_0010,
    S_ENV_UPD  = 11'b000_0000_0100,
    S_KNEE     = 11'b000_0000_1000,
    S_POLY_ADD = 11'b000_0001_0000,
    S_POLY_MUL = 11'b000_0010_0000,
    S_TGT_ADD  = 11'b000_0100_0000,
    S_END_TGT  = 11'b000_1000_0000,
    S_CHECK    = 11'b001_0000_0000,
    S_DIV      = 11'b010_0000_0000,
    S_DONE     = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (enable) begin
            state_next = S_ENV_MUL;
          end else begin
            cmd.env_clear = 1'b1;
            cmd.gain_op   = GAIN_UNITY;
            state_next    = S_DONE;
          end
        end
      end
      S_ENV_MUL: begin
        cmd.mul_sel = MUL_ENV;
        state_next  = S_ENV_UPD;
      end
      S_ENV_UPD: begin
        cmd.env_update = 1'b1;
        state_next     = S_KNEE;
      end
      S_KNEE: begin
        if (!status.above_start) begin
          cmd.gain_op = GAIN_UNITY;
          state_next  = S_DONE;
        end else if (status.above_end) begin
          cmd.mul_sel = MUL_KNEE_END;
          state_next  = S_END_TGT;
        end else begin
          cmd.mul_sel = MUL_SQUARE;
          state_next  = S_POLY_ADD;
        end
      end
      S_POLY_ADD: begin
        cmd.acc_op = ACC_POLY;
        state_next = S_POLY_MUL;
      end
      S_POLY_MUL: begin
        cmd.mul_sel = MUL_POLY;
        state_next  = S_TGT_ADD;
      end
      S_TGT_ADD: begin
        cmd.acc_op = ACC_TARGET;
        state_next = S_CHECK;
      end
      S_END_TGT: begin
        cmd.acc_op = ACC_KNEE_END;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.target_nonpos) begin
          cmd.gain_op = GAIN_ZERO;
          state_next  = S_DONE;
        end else if (status.target_sat) begin
          cmd.gain_op = GAIN_UNITY;
          state_next  = S_DONE;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/alg_dp.sv @@
// ----------------------------------------------------------------------------
// Gain computer datapath
// Envelope register, shared multiplier, target accumulator, restoring divider
// and the output register.
// ----------------------------------------------------------------------------
module alg_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  alg_pkg::alg_cfg_t            cfg,
  input  logic                         cfg_env_clear,
  input  alg_pkg::alg_cmd_t            cmd,
  output alg_pkg::alg_status_t         status,
  input  logic [alg_pkg::LEVEL_W-1:0]  level,
  input  logic                         block_end,
  output logic [alg_pkg::GAIN_W-1:0]   gain,
  output logic                         block_end_out
);
  import alg_pkg::*;

  localparam int SHIFT_W = PROD_W - FRAC_SHIFT;

  logic [LEVEL_W-1:0]       level_reg;
  logic                     block_end_reg;
  logic [ENV_W-1:0]         envelope;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic [ENV_W-1:0]         rem;
  logic [CNT_W-1:0]         cnt;
  logic [GAIN_W-1:0]        gain_res;

  logic [ENV_W-1:0]          level_q28;
  logic                      rising;
  logic [ENV_W-1:0]          env_diff;
  logic [FACTOR_W-1:0]       factor;
  logic [ENV_W-1:0]          env_step;
  logic [LEVEL_W-1:0]        env_q20;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [SHIFT_W-1:0] prod_shift;
  logic signed [SHIFT_W-1:0] addend;
  logic signed [SHIFT_W-1:0] acc_sum;
  logic [ENV_W:0]            rem_shift;
  logic [ENV_W:0]            rem_sub;
  logic                      rem_ge;

  assign level_q28 = {level_reg, 8'h00};
  assign rising    = level_q28 > envelope;
  assign env_diff  = rising ? (level_q28 - envelope) : (envelope - level_q28);
  assign factor    = rising ? cfg.attack : cfg.release_f;
  assign env_step  = prod[ENV_W+23:24];
  assign env_q20   = envelope[ENV_W-1:8];

  always_comb begin
    case (cmd.mul_sel)
      MUL_ENV: begin
        mul_a = $signed({{(MUL_A_W-ENV_W){1'b0}}, env_diff});
        mul_b = $signed({{(MUL_B_W-FACTOR_W){1'b0}}, factor});
      end
      MUL_SQUARE: begin
        mul_a = MUL_A_W'(cfg.square);
        mul_b = $signed({{(MUL_B_W-LEVEL_W){1'b0}}, env_q20});
      end
      MUL_POLY: begin
        mul_a = acc[MUL_A_W-1:0];
        mul_b = $signed({{(MUL_B_W-LEVEL_W){1'b0}}, env_q20});
      end
      MUL_KNEE_END: begin
        mul_a = $signed({{(MUL_A_W-KNEE_W){1'b0}}, cfg.knee_end});
        mul_b = $signed({{(MUL_B_W-KNEE_W){1'b0}}, SQRT_HALF_Q24});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p      = mul_a * mul_b;
  assign prod_shift = prod[PROD_W-1:FRAC_SHIFT];

  always_comb begin
    case (cmd.acc_op)
      ACC_POLY:   addend = SHIFT_W'(cfg.linear);
      ACC_TARGET: addend = SHIFT_W'(cfg.offset);
      default:    addend = '0;
    endcase
  end

  assign acc_sum   = prod_shift + addend;
  assign rem_shift = {rem, 1'b0};
  assign rem_ge    = rem_shift >= {1'b0, envelope};
  assign rem_sub   = rem_shift - {1'b0, envelope};

  assign status.above_start   = envelope > {cfg.knee_start, 8'h00};
  assign status.above_end     = envelope >= {cfg.knee_end, 8'h00};
  assign status.target_nonpos = acc[ACC_W-1] || (acc == '0);
  assign status.target_sat    = {acc, 4'h0} >= {{(ACC_W+4-ENV_W){1'b0}}, envelope};
  assign status.div_last      = (cnt == CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst || cfg_env_clear || cmd.env_clear) begin
      envelope <= '0;
    end else if (cmd.env_update) begin
      envelope <= rising ? (envelope + env_step) : (envelope - env_step);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      level_reg     <= level;
      block_end_reg <= block_end;
    end
    if (cmd.mul_sel != MUL_NONE) begin
      prod <= mul_p;
    end
    if (cmd.acc_op != ACC_NONE) begin
      acc <= acc_sum[ACC_W-1:0];
    end
    if (cmd.div_init) begin
      rem      <= {acc[ENV_W-5:0], 4'h0};
      cnt      <= '0;
      gain_res <= '0;
    end else if (cmd.div_step) begin
      rem      <= rem_ge ? rem_sub[ENV_W-1:0] : rem_shift[ENV_W-1:0];
      cnt      <= cnt + 1'b1;
      gain_res <= {gain_res[GAIN_W-2:0], rem_ge};
    end else begin
      case (cmd.gain_op)
        GAIN_UNITY: gain_res <= UNITY_GAIN;
        GAIN_ZERO:  gain_res <= '0;
        default: begin
        end
      endcase
    end
    if (cmd.load_out) begin
      gain          <= gain_res;
      block_end_out <= block_end_reg;
    end
  end

endmodule

@@ rtl/core/auto_level_gain_computer_core.sv @@
// ----------------------------------------------------------------------------
// Auto level gain computer
// Envelope follower with a soft-knee curve that turns each side-chain level
// sample into a gain factor.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall   level, block_end
//   out      output     out_valid / out_stall gain, block_end_out
//   cfg      input      cfg_write_en          cfg_index, cfg_data
//
// A disabled item goes straight to the output. An enabled item updates the
// envelope and ends there if it stays at or below the knee start; otherwise
// knee curve, checks and 23-step restoring divider for target/envelope run.
// Reset is synchronous and active high; it clears the envelope and loads the
// register defaults. One item is in work at a time; a result waiting in the
// output register does not hold off the next input transfer.
// ----------------------------------------------------------------------------
module auto_level_gain_computer_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_en,
  input  logic [alg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [alg_pkg::LEVEL_W-1:0]    level,
  input  logic                           block_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [alg_pkg::GAIN_W-1:0]     gain,
  output logic                           block_end_out
);
  import alg_pkg::*;

  alg_cfg_t    cfg;
  logic        cfg_env_clear;
  alg_cmd_t    cmd;
  alg_status_t status;

  alg_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg),
    .env_clear    (cfg_env_clear)
  );

  alg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .enable    (cfg.enable),
    .status    (status),
    .cmd       (cmd)
  );

  alg_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cfg_env_clear (cfg_env_clear),
    .cmd           (cmd),
    .status        (status),
    .level         (level),
    .block_end     (block_end),
    .gain          (gain),
    .block_end_out (block_end_out)
  );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Auto level gain computer testbench
// Drives side-chain levels through the core under several register settings,
// predicts every gain from its own envelope and knee arithmetic, and checks
// each output transfer in order while both sides pause and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import alg_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 80;

  typedef struct {
    logic [GAIN_W-1:0] gain;
    logic              block_end;
  } gain_result_t;

  typedef struct {
    bit                    is_write;
    reg_index_t            idx;
    logic [CFG_DATA_W-1:0] data;
    logic [LEVEL_W-1:0]    lv;
    logic                  be;
    bit                    typed;
    logic [GAIN_W-1:0]     gain;
  } plan_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [LEVEL_W-1:0]    level;
  logic                  block_end;
  logic                  out_valid;
  logic                  out_stall;
  logic [GAIN_W-1:0]     gain;
  logic                  block_end_out;

  alg_cfg_t         shadow_cfg;
  logic [ENV_W-1:0] shadow_env;
  gain_result_t     expected_gains[$];
  plan_row_t        directed_plan[$];

  int burst_left;
  int errors;
  int level_count;
  int gain_count;
  int write_count;
  int unity_count;
  int zero_count;
  int mid_count;
  int idle_cycles;

  auto_level_gain_computer_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .level         (level),
    .block_end     (block_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .gain          (gain),
    .block_end_out (block_end_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [FACTOR_W-1:0] factor_limit(logic [CFG_DATA_W-1:0] d);
    logic [FACTOR_W-1:0] f;
    f = d[FACTOR_W-1:0];
    return (f > FACTOR_ONE) ? FACTOR_ONE : f;
  endfunction

  function automatic void shadow_write(reg_index_t idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_ENABLE: begin
        shadow_cfg.enable = d[0];
        if (!d[0]) shadow_env = '0;
      end
      REG_ATTACK:  shadow_cfg.attack = factor_limit(d);
      REG_RELEASE: shadow_cfg.release_f = factor_limit(d);
      REG_KNEE_LO: shadow_cfg.knee_start = d[KNEE_W-1:0];
      REG_KNEE_HI: shadow_cfg.knee_end = d[KNEE_W-1:0];
      REG_SQUARE:  shadow_cfg.square = d;
      REG_LINEAR:  shadow_cfg.linear = d;
      REG_CONST:   shadow_cfg.offset = d;
      default: ;
    endcase
  endfunction

  // Advances the envelope by one level sample and returns the gain it yields.
  function automatic logic [GAIN_W-1:0] predict_gain(logic [LEVEL_W-1:0] lv);
    logic [ENV_W-1:0] lvl;
    logic [63:0]      env64;
    logic [63:0]      tgt_u;
    longint           e;
    longint           sq;
    longint           lin;
    longint           cst;
    longint           p;
    longint           target;
    lvl = {lv, 8'h00};
    if (!shadow_cfg.enable) begin
      shadow_env = '0;
      return UNITY_GAIN;
    end
    if (lvl > shadow_env)
      shadow_env = shadow_env +
                   ENV_W'((64'(shadow_cfg.attack) * 64'(lvl - shadow_env)) >> 24);
    else
      shadow_env = shadow_env -
                   ENV_W'((64'(shadow_cfg.release_f) * 64'(shadow_env - lvl)) >> 24);
    env64 = 64'(shadow_env);
    if (env64 <= (64'(shadow_cfg.knee_start) << 8)) return UNITY_GAIN;
    if (env64 >= (64'(shadow_cfg.knee_end) << 8)) begin
      target = longint'((64'(shadow_cfg.knee_end) * 64'(SQRT_HALF_Q24)) >> 20);
    end else begin
      e      = longint'(env64 >> 8);
      sq     = {{32{shadow_cfg.square[COEF_W-1]}}, shadow_cfg.square};
      lin    = {{32{shadow_cfg.linear[COEF_W-1]}}, shadow_cfg.linear};
      cst    = {{32{shadow_cfg.offset[COEF_W-1]}}, shadow_cfg.offset};
      p      = ((sq * e) >>> FRAC_SHIFT) + lin;
      target = ((p * e) >>> FRAC_SHIFT) + cst;
    end
    if (target <= 0) return '0;
    tgt_u = 64'(target);
    if (tgt_u >= ((env64 + 15) >> 4) && (tgt_u << 4) >= env64) return UNITY_GAIN;
    tgt_u = (tgt_u << 27) / env64;
    return tgt_u[GAIN_W-1:0];
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_factor();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CFG_DATA_W'(FACTOR_ONE);
      2:       return $urandom;
      3:       return $urandom_range(32'h0100_0000, 32'h01FF_FFFF);
      default: return $urandom_range(32'h0000_4000, 32'h0100_0000);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_coef(int mode);
    case (mode)
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 2))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          default: return '0;
        endcase
      end
      default: return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
    endcase
  endfunction

  function automatic void add_write(reg_index_t idx, logic [CFG_DATA_W-1:0] d);
    plan_row_t r;
    r = '{is_write: 1'b1, idx: idx, data: d, lv: '0, be: 1'b0, typed: 1'b0, gain: '0};
    directed_plan.push_back(r);
  endfunction

  function automatic void add_level(logic [LEVEL_W-1:0] lv, logic be, bit typed,
                                    logic [GAIN_W-1:0] g);
    plan_row_t r;
    r = '{is_write: 1'b0, idx: REG_ENABLE, data: '0, lv: lv, be: be, typed: typed, gain: g};
    directed_plan.push_back(r);
  endfunction

  task automatic send_level(logic [LEVEL_W-1:0] lv, logic be, bit typed,
                            logic [GAIN_W-1:0] typed_gain);
    gain_result_t r;
    r.gain = predict_gain(lv);
    if (typed) r.gain = typed_gain;
    r.block_end = be;
    expected_gains.push_back(r);
    @(negedge clk);
    in_valid  = 1'b1;
    level     = lv;
    block_end = be;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk) in_valid = 1'b0;
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(13, 40)) @(negedge clk);
      else
        repeat ($urandom_range(0, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk) in_valid = 1'b0;
    while (expected_gains.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_write_en = 1'b1;
    cfg_index    = idx;
    cfg_data     = d;
    @(negedge clk);
    cfg_write_en = 1'b0;
    shadow_write(idx, d);
    write_count++;
  endtask

  initial begin
    bit hold;
    int run;
    out_stall = 1'b0;
    forever begin
      case ($urandom_range(0, 3))
        0: begin hold = 1'b0; run = $urandom_range(20, 80); end
        1: begin hold = 1'b1; run = $urandom_range(1, 3); end
        2: begin hold = 1'b0; run = $urandom_range(1, 4); end
        default: begin hold = 1'b1; run = $urandom_range(5, 20); end
      endcase
      @(negedge clk) out_stall = hold;
      repeat (run - 1) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    bit           moved;
    gain_result_t want;
    moved = 1'b0;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        level_count++;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        gain_count++;
        if (gain == UNITY_GAIN) unity_count++;
        else if (gain == '0) zero_count++;
        else mid_count++;
        if (expected_gains.size() == 0) begin
          errors++;
          $display("%0t: gain transfer with none expected: gain %h block_end_out %b",
                   $time, gain, block_end_out);
        end else begin
          want = expected_gains.pop_front();
          if (gain !== want.gain) begin
            errors++;
            $display("%0t: gain expected %h actual %h", $time, want.gain, gain);
          end
          if (block_end_out !== want.block_end) begin
            errors++;
            $display("%0t: block_end_out expected %b actual %b",
                     $time, want.block_end, block_end_out);
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d gains outstanding",
                 $time, idle_cycles, expected_gains.size());
        $display("** auto_level_gain_computer_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    plan_row_t          row;
    logic [LEVEL_W-1:0] lv;
    logic [LEVEL_W-1:0] last_lv;
    logic [KNEE_W-1:0]  ks;
    logic [KNEE_W-1:0]  ke;
    int                 lo;
    int                 hi;
    int                 coef_mode;

    rst          = 1'b1;
    cfg_write_en = 1'b0;
    cfg_index    = REG_ENABLE;
    cfg_data     = '0;
    in_valid     = 1'b0;
    level        = '0;
    block_end    = 1'b0;
    burst_left   = 1;
    errors       = 0;
    level_count  = 0;
    gain_count   = 0;
    write_count  = 0;
    unity_count  = 0;
    zero_count   = 0;
    mid_count    = 0;
    last_lv      = '0;

    shadow_cfg.enable     = 1'b0;
    shadow_cfg.attack     = FACTOR_ONE;
    shadow_cfg.release_f  = FACTOR_ONE;
    shadow_cfg.knee_start = 24'hFF_FFFF;
    shadow_cfg.knee_end   = 24'hFF_FFFF;
    shadow_cfg.square     = '0;
    shadow_cfg.linear     = 32'sd16777216;
    shadow_cfg.offset     = '0;
    shadow_env            = '0;

    repeat (7) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // Disabled after reset, then enabled with the knee start at its maximum.
    add_level(24'hFF_FFFF, 1'b1, 1'b1, UNITY_GAIN);
    add_level(24'h00_0000, 1'b0, 1'b1, UNITY_GAIN);
    add_write(REG_ENABLE, 32'd1);
    add_level(24'hFF_FFFF, 1'b1, 1'b1, UNITY_GAIN);
    add_level(24'h00_0000, 1'b0, 1'b1, UNITY_GAIN);
    // Factors above one, a linear knee from 1.0 to 4.0.
    add_write(REG_ATTACK, 32'h01FF_FFFF);
    add_write(REG_RELEASE, 32'hFFFF_FFFF);
    add_write(REG_KNEE_LO, 32'h0010_0000);
    add_write(REG_KNEE_HI, 32'h0040_0000);
    add_write(REG_SQUARE, 32'h0000_0000);
    add_write(REG_LINEAR, 32'h0100_0000);
    add_write(REG_CONST, 32'h0000_0000);
    add_level(24'h08_0000, 1'b0, 1'b1, UNITY_GAIN);
    add_level(24'h20_0000, 1'b1, 1'b1, UNITY_GAIN);
    add_level(24'hFF_FFFF, 1'b0, 1'b0, '0);
    add_level(24'h40_0000, 1'b1, 1'b0, '0);
    // A negative target and then a zero target both give zero gain.
    add_write(REG_CONST, 32'h8000_0000);
    add_level(24'h20_0000, 1'b0, 1'b1, '0);
    add_write(REG_CONST, 32'h0000_0000);
    add_write(REG_LINEAR, 32'h0000_0000);
    add_level(24'h30_0000, 1'b1, 1'b1, '0);
    add_write(REG_SQUARE, 32'h7FFF_FFFF);
    add_write(REG_LINEAR, 32'h8000_0000);
    add_write(REG_CONST, 32'h7FFF_FFFF);
    add_level(24'h18_0000, 1'b0, 1'b0, '0);
    add_level(24'h3F_FFFF, 1'b1, 1'b0, '0);
    // Knee end below knee start.
    add_write(REG_KNEE_LO, 32'h0030_0000);
    add_write(REG_KNEE_HI, 32'h0010_0000);
    add_level(24'h20_0000, 1'b0, 1'b1, UNITY_GAIN);
    add_level(24'h40_0000, 1'b1, 1'b0, '0);
    add_write(REG_KNEE_LO, 32'h0000_0000);
    add_write(REG_KNEE_HI, 32'h00FF_FFFF);
    add_write(REG_SQUARE, 32'h0000_0000);
    add_write(REG_LINEAR, 32'h00C0_0000);
    add_write(REG_CONST, 32'h0000_0000);
    add_level(24'h00_0000, 1'b0, 1'b1, UNITY_GAIN);
    // Slow attack and a frozen release.
    add_write(REG_ATTACK, 32'h0010_0000);
    add_write(REG_RELEASE, 32'h0000_0000);
    add_level(24'hFF_FFFF, 1'b1, 1'b0, '0);
    add_level(24'hFF_FFFF, 1'b0, 1'b0, '0);
    add_level(24'h00_0000, 1'b1, 1'b0, '0);
    add_write(REG_RELEASE, 32'h0100_0000);
    add_level(24'h00_0001, 1'b0, 1'b0, '0);
    add_write(REG_ENABLE, 32'd0);
    add_level(24'h12_3456, 1'b0, 1'b1, UNITY_GAIN);
    add_level(24'hAB_CDEF, 1'b1, 1'b1, UNITY_GAIN);

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.is_write) begin
        wait_drained();
        write_reg(row.idx, row.data);
      end else begin
        send_level(row.lv, row.be, row.typed, row.gain);
      end
    end
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: begin ks = '0; ke = 24'hFF_FFFF; end
        1: begin ks = KNEE_W'($urandom); ke = KNEE_W'($urandom); end
        default: begin
          ks = KNEE_W'($urandom_range(0, 24'h40_0000));
          ke = KNEE_W'(ks + $urandom_range(1, 24'h80_0000));
        end
      endcase
      coef_mode = $urandom_range(0, 4);
      write_reg(REG_ENABLE, (ph == 3) ? 32'd0 : 32'd1);
      write_reg(REG_ATTACK, pick_factor());
      write_reg(REG_RELEASE, pick_factor());
      write_reg(REG_KNEE_LO, CFG_DATA_W'(ks));
      write_reg(REG_KNEE_HI, CFG_DATA_W'(ke));
      write_reg(REG_SQUARE, pick_coef(coef_mode));
      if (coef_mode >= 2)
        write_reg(REG_LINEAR, $urandom_range(32'h0040_0000, 32'h0200_0000));
      else
        write_reg(REG_LINEAR, pick_coef(coef_mode));
      write_reg(REG_CONST, pick_coef(coef_mode));
      lo = int'(ks) / 2;
      hi = int'(ke) * 2;
      if (hi > 24'hFF_FFFF) hi = 24'hFF_FFFF;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2 && (ph == 0 || $urandom_range(0, 1) == 1)) wait_drained();
        case ($urandom_range(0, 9))
          0, 1:    lv = LEVEL_W'($urandom);
          2:       lv = $urandom_range(0, 1) ? 24'hFF_FFFF : 24'h00_0000;
          3, 4, 5,
          6:       lv = LEVEL_W'($urandom_range(lo, hi));
          default: lv = last_lv;
        endcase
        send_level(lv, 1'($urandom_range(0, 1)), 1'b0, '0);
        last_lv = lv;
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d levels and took %0d gains across %0d register writes in %0d settings.",
             level_count, gain_count, write_count, RAND_PHASES);
    $display("Gains seen: %0d unity, %0d zero, %0d between; %0d mismatches.",
             unity_count, zero_count, mid_count, errors);
    if (errors == 0)
      $display("** auto_level_gain_computer_core: PASSED **");
    else
      $display("** auto_level_gain_computer_core: FAILED **");
    $finish;
  end

endmodule
